// ===== hdl/vti_pkg.sv =====
// Shared types and constants for the VLAN tag insert / truncate block.
// No dependencies; imported by every module of the block but the checker.
package vti_pkg;

  localparam int LEN_W = 17;
  localparam int VID_W = 12;

  localparam int MAX_FRAME = 65536;
  localparam int MAC_BYTES = 2 * 6;
  localparam int TAG_BYTES = 4;
  localparam int TAG_END = MAC_BYTES + TAG_BYTES;

  localparam logic [7:0] TPID_HI = 8'h81;
  localparam logic [7:0] TPID_LO = 8'h00;

  localparam logic [LEN_W-1:0] POS_MAX = '1;

  localparam int QUEUE_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    REG_VLAN_ID     = 2'd0,
    REG_SNAP_LENGTH = 2'd1,
    REG_TAIL_TRIM   = 2'd2
  } reg_idx_t;

  // One queue entry: the result bytes caused by one accepted input byte.
  typedef struct packed {
    logic             drop;
    logic             byte_vld;
    logic [7:0]       data;
    logic             byte_eof;
    logic [2:0]       tag_cnt;
    logic             tag_eof;
    logic [VID_W-1:0] vid;
  } vti_entry_t;

endpackage

// ===== hdl/vlan_tag_insert_truncate.sv =====
// VLAN tag insertion with truncation, top level: front end, request queue, back end.
// Results of an accepted byte pass the QUEUE_DEPTH queue, then the output register.
// Throughput: one input byte per cycle while not full; one result per cycle out
// while pop is high. The byte before the tag yields up to 5 results, drained at one
// per cycle; back-to-back inserting frames fill the queue and then stall the input.
// Synchronous reset clears control state, not queue slots or output data.
module vlan_tag_insert_truncate #(
  parameter int QUEUE_DEPTH = vti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [16:0] frame_length,
  input  logic        last_byte,
  input  logic        tag_present,
  input  logic [15:0] tag_control,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        end_of_frame,
  output logic        frame_dropped
);
  import vti_pkg::*;

  logic       accept;
  logic       entry_push;
  vti_entry_t entry;
  logic       head_valid;
  vti_entry_t head;
  logic       head_pop;

  assign accept = push && !full;

  vti_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .last_byte    (last_byte),
    .tag_present  (tag_present),
    .tag_control  (tag_control),
    .entry_push   (entry_push),
    .entry        (entry)
  );

  vti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_push),
    .wr_entry (entry),
    .full     (full),
    .rd_en    (head_pop),
    .rd_entry (head),
    .rd_valid (head_valid)
  );

  vti_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_frame  (end_of_frame),
    .frame_dropped (frame_dropped)
  );

endmodule

// ===== hdl/vti_front.sv =====
// Front end: configuration registers, per-frame setup and byte classification.
// Depends on vti_pkg; produces one vti_entry_t per accepted byte with results.
module vti_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [16:0]             cfg_data,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic [16:0]             frame_length,
  input  logic                    last_byte,
  input  logic                    tag_present,
  input  logic [15:0]             tag_control,
  output logic                    entry_push,
  output vti_pkg::vti_entry_t     entry
);
  import vti_pkg::*;

  logic [VID_W-1:0] vlan_id;
  logic [LEN_W-1:0] snap_length;
  logic [LEN_W-1:0] tail_trim;

  logic [LEN_W-1:0] in_pos;
  logic [LEN_W-1:0] out_pos;
  logic             learned_valid;
  logic [VID_W-1:0] learned_vid;
  logic [VID_W-1:0] frame_vid;
  logic [LEN_W-1:0] frame_out_length;
  logic             frame_failed;

  logic             first;
  logic             lv_next;
  logic [VID_W-1:0] lvid_next;
  logic [VID_W-1:0] new_vid;
  logic [LEN_W:0]   len_ext;
  logic             new_fail;
  logic [LEN_W-1:0] nx0, nx1, nx2;

  logic [VID_W-1:0] cur_vid;
  logic             cur_fail;
  logic [LEN_W-1:0] cur_fol;
  logic [LEN_W-1:0] cur_op;
  logic             ins;
  logic [LEN_W:0]   idx;
  logic [LEN_W:0]   fol_ext;
  logic             byte_ok;
  logic             byte_eof;
  logic             is_tag;
  logic [2:0]       tag_cnt;
  logic             tag_eof;
  logic [LEN_W-1:0] op_after;
  logic             drop_late;

  always_comb begin
    first     = (in_pos == '0);
    lv_next   = tag_present ? 1'b1 : learned_valid;
    lvid_next = tag_present ? tag_control[VID_W-1:0] : learned_vid;
    new_vid   = lv_next ? lvid_next : vlan_id;

    len_ext  = {1'b0, frame_length} + (LEN_W+1)'(TAG_BYTES);
    new_fail = (new_vid != '0) &&
               ((len_ext > (LEN_W+1)'(MAX_FRAME)) || (frame_length <= LEN_W'(MAC_BYTES)));
    if (new_fail) begin
      nx0 = '0;
    end else if (new_vid != '0) begin
      nx0 = len_ext[LEN_W-1:0];
    end else begin
      nx0 = frame_length;
    end
    nx1 = (snap_length != '0 && nx0 > snap_length) ? snap_length : nx0;
    nx2 = (tail_trim != '0 && nx1 > tail_trim) ? nx1 - tail_trim : nx1;

    cur_vid  = first ? new_vid : frame_vid;
    cur_fail = first ? new_fail : frame_failed;
    cur_fol  = first ? nx2 : frame_out_length;
    cur_op   = first ? '0 : out_pos;

    ins = (cur_vid != '0);
    // past the MAC addresses an inserting frame shifts by the tag length
    if (ins && in_pos >= LEN_W'(MAC_BYTES)) begin
      idx = {1'b0, in_pos} + (LEN_W+1)'(TAG_BYTES);
    end else begin
      idx = {1'b0, in_pos};
    end
    fol_ext  = {1'b0, cur_fol};
    byte_ok  = (idx < fol_ext);
    byte_eof = ((idx + (LEN_W+1)'(1)) == fol_ext);

    is_tag = ins && (in_pos == LEN_W'(MAC_BYTES - 1));
    if (!is_tag) begin
      tag_cnt = '0;
    end else if (cur_fol >= LEN_W'(TAG_END)) begin
      tag_cnt = 3'(TAG_BYTES);
    end else if (cur_fol > LEN_W'(MAC_BYTES)) begin
      tag_cnt = 3'(cur_fol - LEN_W'(MAC_BYTES));
    end else begin
      tag_cnt = '0;
    end
    tag_eof = is_tag && (cur_fol > LEN_W'(MAC_BYTES)) && (cur_fol <= LEN_W'(TAG_END));

    if (tag_cnt != '0) begin
      op_after = LEN_W'(MAC_BYTES) + LEN_W'(tag_cnt);
    end else if (byte_ok) begin
      op_after = idx[LEN_W-1:0] + LEN_W'(1);
    end else begin
      op_after = cur_op;
    end
    drop_late = last_byte && (op_after < cur_fol);

    entry.drop     = cur_fail || drop_late;
    entry.byte_vld = byte_ok;
    entry.data     = data_byte;
    entry.byte_eof = byte_eof;
    entry.tag_cnt  = tag_cnt;
    entry.tag_eof  = tag_eof;
    entry.vid      = cur_vid;

    if (cur_fail) begin
      entry_push = accept && first;
    end else if (drop_late) begin
      entry_push = accept;
    end else begin
      entry_push = accept && (byte_ok || tag_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_id          <= '0;
      snap_length      <= '0;
      tail_trim        <= '0;
      in_pos           <= '0;
      out_pos          <= '0;
      learned_valid    <= 1'b0;
      learned_vid      <= '0;
      frame_vid        <= '0;
      frame_out_length <= '0;
      frame_failed     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_VLAN_ID:     vlan_id     <= cfg_data[VID_W-1:0];
          REG_SNAP_LENGTH: snap_length <= cfg_data[LEN_W-1:0];
          REG_TAIL_TRIM:   tail_trim   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (first) begin
          learned_valid <= lv_next;
          learned_vid   <= lvid_next;
        end
        frame_vid        <= cur_vid;
        frame_failed     <= cur_fail;
        frame_out_length <= cur_fol;
        out_pos          <= op_after;
        if (last_byte) begin
          in_pos <= '0;
        end else if (in_pos != POS_MAX) begin
          in_pos <= in_pos + LEN_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/vti_queue.sv =====
// Small register queue of classified requests between front and back end.
// Depends on vti_pkg for the entry type.
module vti_queue #(
  parameter int DEPTH = vti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  vti_pkg::vti_entry_t wr_entry,
  output logic                full,
  input  logic                rd_en,
  output vti_pkg::vti_entry_t rd_entry,
  output logic                rd_valid
);
  import vti_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vti_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/vti_back.sv =====
// Back end: expands each queued request into result bytes, one per cycle while the
// output register is empty or popped, into the output register. Depends on vti_pkg.
module vti_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  vti_pkg::vti_entry_t head,
  output logic                head_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                end_of_frame,
  output logic                frame_dropped
);
  import vti_pkg::*;

  logic       out_valid;
  logic [2:0] step;
  logic [2:0] total;
  logic [2:0] tag_k;
  logic [1:0] tsel;
  logic       last_elem;
  logic       load;
  logic [7:0] e_data;
  logic       e_eof;
  logic       e_drop;

  always_comb begin
    total     = {2'b00, head.byte_vld} + head.tag_cnt;
    tag_k     = step - {2'b00, head.byte_vld};
    tsel      = tag_k[1:0];
    last_elem = head.drop || ((step + 3'd1) == total);

    e_drop = 1'b0;
    if (head.drop) begin
      e_data = '0;
      e_eof  = 1'b1;
      e_drop = 1'b1;
    end else if (head.byte_vld && step == '0) begin
      e_data = head.data;
      e_eof  = head.byte_eof;
    end else begin
      case (tsel)
        2'd0:    e_data = TPID_HI;
        2'd1:    e_data = TPID_LO;
        2'd2:    e_data = {4'h0, head.vid[11:8]};
        default: e_data = head.vid[7:0];
      endcase
      e_eof = head.tag_eof && (tag_k == head.tag_cnt - 3'd1);
    end
  end

  assign load     = head_valid && (!out_valid || pop);
  assign head_pop = load && last_elem;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last_elem ? '0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= e_data;
      end_of_frame  <= e_eof;
      frame_dropped <= e_drop;
    end
  end

endmodule

// ===== hdl/vti_checker.sv =====
// Port-level checker for vlan_tag_insert_truncate, bound to the top level.
// No package dependency.
module vti_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       end_of_frame,
  input logic       frame_dropped
);

  // nothing waits on the output right after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible after reset");

  a_not_full_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("queue full after reset");

  // a drop mark always closes the frame and carries a zero byte
  a_drop_mark: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_dropped) |-> (end_of_frame && out_byte == 8'h00))
    else $error("malformed drop mark");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_frame)
                          && $stable(frame_dropped)))
    else $error("waiting result changed");

endmodule

bind vlan_tag_insert_truncate vti_checker u_vti_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_byte      (out_byte),
  .end_of_frame  (end_of_frame),
  .frame_dropped (frame_dropped)
);

// ===== bench/vlan_tag_insert_truncate_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for vlan_tag_insert_truncate: byte stream in, rewritten stream out.
// Tracks tag insertion, learned ID, snap cut and tail trim in a local predictor.
// Depends on vti_pkg and the vlan_tag_insert_truncate RTL only.
module vlan_tag_insert_truncate_tb;
  import vti_pkg::*;

  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       drop;
  } tx_byte_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic [16:0] frame_length;
  logic        last_byte;
  logic        tag_present;
  logic [15:0] tag_control;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        end_of_frame;
  logic        frame_dropped;

  // predictor state
  int unsigned rx_pos;
  int unsigned tx_pos;
  int unsigned tx_len;
  logic        learned_ok;
  logic [11:0] learned_id;
  logic [11:0] frame_id;
  logic        frame_bad;
  logic [11:0] cfg_vid;
  int unsigned cfg_snap;
  int unsigned cfg_trim;

  tx_byte_t expected_bytes[$];
  tx_byte_t step_bytes[$];
  tx_byte_t want_rec;

  int  bytes_in;
  int  frames_in;
  int  bytes_out;
  int  drops_out;
  int  errors;
  int  stall_cycles;
  int  hold_cnt;
  bit  in_idle_en;
  bit  out_idle_en;
  bit  long_hold_req;

  vlan_tag_insert_truncate uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .last_byte    (last_byte),
    .tag_present  (tag_present),
    .tag_control  (tag_control),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame),
    .frame_dropped(frame_dropped)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // queue one outgoing byte if it falls inside the frame's output length
  function automatic void place_at(int unsigned idx, logic [7:0] b);
    if (idx < tx_len) begin
      step_bytes.push_back('{b, (idx == tx_len - 1), 1'b0});
      tx_pos = idx + 1;
    end
  endfunction

  function automatic void predict_rewrite(logic [7:0] d, logic [16:0] len, logic lst,
                                          logic tg, logic [15:0] tc);
    int unsigned nx;
    int unsigned idx;
    int unsigned pos;
    logic        first;
    logic        ins;
    pos   = rx_pos;
    first = (rx_pos == 0);
    step_bytes.delete();
    if (first) begin
      nx = len;
      if (tg) begin
        learned_ok = 1'b1;
        learned_id = tc[11:0];
      end
      frame_id  = learned_ok ? learned_id : cfg_vid;
      frame_bad = 1'b0;
      if (frame_id != 0) begin
        if (len + TAG_BYTES > MAX_FRAME || len <= MAC_BYTES)
          frame_bad = 1'b1;
        else
          nx = len + TAG_BYTES;
      end
      if (frame_bad)
        nx = 0;
      if (cfg_snap != 0 && nx > cfg_snap)
        nx = cfg_snap;
      if (cfg_trim != 0 && nx > cfg_trim)
        nx -= cfg_trim;
      tx_len = nx & POS_MAX;
      tx_pos = 0;
    end
    if (frame_bad) begin
      if (first)
        step_bytes.push_back('{8'h00, 1'b1, 1'b1});
    end else begin
      ins = (frame_id != 0);
      idx = (ins && pos >= MAC_BYTES) ? pos + TAG_BYTES : pos;
      place_at(idx, d);
      if (ins && pos == MAC_BYTES - 1) begin
        place_at(MAC_BYTES,     TPID_HI);
        place_at(MAC_BYTES + 1, TPID_LO);
        place_at(MAC_BYTES + 2, {4'h0, frame_id[11:8]});
        place_at(MAC_BYTES + 3, frame_id[7:0]);
      end
      // frame ended before its last outgoing byte: the step gives only a drop mark
      if (lst && tx_pos < tx_len) begin
        step_bytes.delete();
        step_bytes.push_back('{8'h00, 1'b1, 1'b1});
      end
    end
    if (lst)
      rx_pos = 0;
    else if (rx_pos < POS_MAX)
      rx_pos++;
    foreach (step_bytes[k])
      expected_bytes.push_back(step_bytes[k]);
  endfunction

  // hold each request until the block takes it
  task automatic send_byte(logic [7:0] d, logic [16:0] len, logic lst, logic tg,
                           logic [15:0] tc);
    if (in_idle_en && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    @(negedge clk);
    push         <= 1'b1;
    data_byte    <= d;
    frame_length <= len;
    last_byte    <= lst;
    tag_present  <= tg;
    tag_control  <= tc;
    do @(posedge clk); while (full);
    predict_rewrite(d, len, lst, tg, tc);
    bytes_in++;
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(int unsigned len, int unsigned cnt, logic tg, logic [15:0] tc,
                            int fill);
    logic [7:0] d;
    for (int unsigned i = 0; i < cnt; i++) begin
      d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      send_byte(d, len[16:0], (i == cnt - 1), tg, tc);
    end
    frames_in++;
  endtask

  task automatic random_frame();
    int unsigned len;
    int unsigned cnt;
    int unsigned kind;
    logic        tg;
    logic [15:0] tc;
    kind = $urandom_range(0, 9);
    tg   = ($urandom_range(0, 3) == 0);
    tc   = 16'($urandom);
    if ($urandom_range(0, 3) == 0)
      tc[11:0] = '0;
    if (kind <= 5) begin
      len = $urandom_range(0, 40);
      cnt = (len == 0) ? 1 : len;
    end else if (kind == 6) begin
      len = $urandom_range(MAC_BYTES + 1, 60);
      cnt = $urandom_range(1, len - 1);
    end else if (kind == 7) begin
      len = $urandom_range(0, 20);
      cnt = len + $urandom_range(1, 6);
    end else if (kind == 8) begin
      case ($urandom_range(0, 3))
        0:       len = MAX_FRAME;
        1:       len = MAX_FRAME - TAG_BYTES;
        2:       len = MAX_FRAME - TAG_BYTES + 1;
        default: len = $urandom_range(41, MAX_FRAME);
      endcase
      cnt = $urandom_range(1, 16);
    end else begin
      len = MAC_BYTES - 1 + $urandom_range(0, 3);
      cnt = len;
    end
    send_frame(len, cnt, tg, tc, -1);
  endtask

  // stop sending and wait for every outstanding result, plus pipeline slack
  task automatic drain_outputs();
    @(negedge clk);
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_VLAN_ID:     cfg_vid  = val[11:0];
      REG_SNAP_LENGTH: cfg_snap = val;
      REG_TAIL_TRIM:   cfg_trim = val;
      default: ;
    endcase
  endtask

  task automatic test_plain_frames();
    write_reg(REG_VLAN_ID, 17'd0);
    send_frame(0, 1, 1'b0, 16'h0000, 8'hff);   // zero length: nothing out
    send_frame(2, 4, 1'b0, 16'h0000, 8'hff);   // surplus bytes dropped silently
    send_frame(5, 2, 1'b0, 16'h0000, 8'hff);   // ends early
  endtask

  task automatic test_tag_insert();
    drain_outputs();
    write_reg(REG_VLAN_ID, 17'd4095);
    write_reg(REG_SNAP_LENGTH, 17'd65536);
    write_reg(REG_TAIL_TRIM, 17'd65536);
    send_frame(MAC_BYTES + 1, MAC_BYTES + 1, 1'b0, 16'h0000, 8'h00);
    send_frame(MAC_BYTES, 1, 1'b0, 16'h0000, 8'h00);                  // too short to tag
    send_frame(MAX_FRAME - TAG_BYTES + 1, 1, 1'b0, 16'h0000, 8'h00);  // too long to tag
    send_frame(MAX_FRAME, 2, 1'b0, 16'h0000, 8'h00);
  endtask

  task automatic test_learned_id();
    // a learned ID of zero overrides the configured one
    send_frame(3, 3, 1'b1, 16'hf000, -1);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_start;
    for (int ph = 0; ph < 4; ph++) begin
      drain_outputs();
      write_reg(REG_VLAN_ID, 17'($urandom_range(0, 4095)));
      case (ph)
        0: begin
          write_reg(REG_SNAP_LENGTH, 17'd0);
          write_reg(REG_TAIL_TRIM, 17'd0);
        end
        1: begin
          write_reg(REG_SNAP_LENGTH, 17'($urandom_range(MAC_BYTES + 1, 30)));
          write_reg(REG_TAIL_TRIM, 17'd65536);
        end
        2: begin
          write_reg(REG_SNAP_LENGTH, 17'd65536);
          write_reg(REG_TAIL_TRIM, 17'($urandom_range(1, 10)));
        end
        default: begin
          write_reg(REG_SNAP_LENGTH, 17'($urandom_range(1, 40)));
          write_reg(REG_TAIL_TRIM, 17'($urandom_range(1, 10)));
        end
      endcase
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      phase_start = bytes_in;
      while (bytes_in - phase_start < 12)
        random_frame();
    end
  endtask

  task automatic test_output_stall();
    drain_outputs();
    write_reg(REG_SNAP_LENGTH, 17'd0);
    write_reg(REG_TAIL_TRIM, 17'd0);
    in_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    send_frame(40, 40, 1'b1, 16'h0abc, -1);
    // sender waits for the stream to empty before going on
    drain_outputs();
  endtask

  task automatic test_surplus_bytes();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    // bytes past the sampled length, sent back to back, must give nothing
    send_frame(20, 26, 1'b1, 16'h0005, -1);
  endtask

  // result side: random pop bursts, one long hold on request
  initial begin
    pop      = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_cnt > 0) begin
        pop <= 1'b0;
        hold_cnt--;
      end else if (long_hold_req) begin
        pop <= 1'b0;
        hold_cnt = LONG_HOLD - 1;
        long_hold_req = 1'b0;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        hold_cnt = $urandom_range(0, 14);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      bytes_out++;
      if (frame_dropped)
        drops_out++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte=%02h eof=%b drop=%b, nothing expected",
                 $time, out_byte, end_of_frame, frame_dropped);
      end else begin
        want_rec = expected_bytes.pop_front();
        if (want_rec.data !== out_byte || want_rec.eof !== end_of_frame ||
            want_rec.drop !== frame_dropped) begin
          errors++;
          $display("%0t: output differs: expected byte=%02h eof=%b drop=%b, got byte=%02h eof=%b drop=%b",
                   $time, want_rec.data, want_rec.eof, want_rec.drop,
                   out_byte, end_of_frame, frame_dropped);
        end
      end
    end
  end

  // watchdog on cycles in which no request moves on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d results still outstanding", expected_bytes.size());
        $display("vlan_tag_insert_truncate: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    push         = 1'b0;
    data_byte    = '0;
    frame_length = '0;
    last_byte    = 1'b0;
    tag_present  = 1'b0;
    tag_control  = '0;
    rx_pos       = 0;
    tx_pos       = 0;
    tx_len       = 0;
    learned_ok   = 1'b0;
    learned_id   = '0;
    frame_id     = '0;
    frame_bad    = 1'b0;
    cfg_vid      = '0;
    cfg_snap     = 0;
    cfg_trim     = 0;
    bytes_in     = 0;
    frames_in    = 0;
    bytes_out    = 0;
    drops_out    = 0;
    errors       = 0;
    stall_cycles = 0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_frames();
    test_tag_insert();
    test_learned_id();
    test_random_traffic();
    test_output_stall();
    test_surplus_bytes();

    drain_outputs();
    repeat (10) @(posedge clk);
    $display("ran %0d frames / %0d input bytes, checked %0d output bytes (%0d drop marks)",
             frames_in, bytes_in, bytes_out, drops_out);
    $display("covered tag insert, learned ID, snap/trim settings, stalls, surplus bytes");
    if (errors == 0) begin
      $display("vlan_tag_insert_truncate: match");
    end else begin
      $display("vlan_tag_insert_truncate: mismatch");
    end
    $finish;
  end

endmodule
